FILE: sv/pssr_pkg.sv
`default_nettype none

package pssr_pkg;

	// Field widths fixed by the point format (signed Q16.4)
	localparam int COORD_BITS   = 20;
	localparam int THRESH_BITS  = 20;
	localparam int METHOD_BITS  = 2;
	localparam int CFG_IDX_BITS = 1;

	// Default cluster length cap for the mean
	localparam int MAX_PATH_POINTS_DEF = 4096;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_METHOD = 1'd1;

	// Merge method codes
	localparam logic [METHOD_BITS-1:0] MERGE_FIRST = 2'd0;
	localparam logic [METHOD_BITS-1:0] MERGE_LAST  = 2'd1;
	localparam logic [METHOD_BITS-1:0] MERGE_MEAN  = 2'd2;

	localparam logic [THRESH_BITS-1:0] THRESHOLD_RST = 20'd16;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         end_of_path;
	} pt_beat_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic                         out_last;
	} res_beat_t;

	// Controller to datapath
	typedef struct packed {
		logic load_pt;
		logic set_anchor_pt;
		logic set_anchor_last;
		logic set_anchor_mean;
		logic open_cluster;
		logic join_cluster;
		logic start_div;
		logic emit;
		logic emit_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic                   lt;
		logic                   gt;
		logic                   end_pt;
		logic                   div_done;
		logic                   res_free;
		logic [METHOD_BITS-1:0] method;
	} sts_t;

endpackage

`default_nettype wire

FILE: sv/polyline_small_segment_remover.sv
`default_nettype none

// Streaming small-segment remover for polylines. Points (signed Q16.4) come in one beat
// at a time with end_of_path on the final one; kept points go out with out_last on the
// path's final point. A point passes three steps (accept, square, compare) through the
// single squared-distance unit; emitted points wait in the emit state until the output is free.
// Closing a cluster adds a close step; a closing point that left the cluster is then
// squared and compared again, and the mean method waits for the bit-serial divider.
// Registers: index 0 threshold, index 1 merge method (0 first, 1 last, 2 mean, 3 as 0);
// the user must write them only while idle; the block does not enforce this.
module polyline_small_segment_remover #(
	parameter int MAX_PATH_POINTS = pssr_pkg::MAX_PATH_POINTS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               pt_valid,
	output logic                                    pt_stall,
	input  wire pssr_pkg::pt_beat_t                 pt_data,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output pssr_pkg::res_beat_t                     res_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pssr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [pssr_pkg::THRESH_BITS-1:0]   cfg_data
);
	import pssr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	pssr_dp #(.MAX_PATH_POINTS(MAX_PATH_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_data   (pt_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

FILE: sv/pssr_div.sv
`default_nettype none

// Rounded mean: q = (2|sum| + n) / (2n), one quotient bit per cycle, sign restored
module pssr_div #(
	parameter int SUM_W = 33,
	parameter int CNT_W = 13
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [SUM_W-1:0]              sum,
	input  wire logic        [CNT_W-1:0]              count,
	output logic                                      done,
	output logic signed [pssr_pkg::COORD_BITS-1:0]    mean
);
	import pssr_pkg::*;

	localparam int NUM_W = SUM_W + 2;
	localparam int DIV_W = CNT_W + 1;
	localparam int REM_W = CNT_W + 1;
	localparam int STP_W = $clog2(NUM_W);

	logic [SUM_W-1:0] mag;
	logic [NUM_W-1:0] num_init;
	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W:0]   trial;
	logic             take;
	logic [STP_W-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [COORD_BITS-1:0] quo;

	// Operand preparation
	assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign num_init = NUM_W'({mag, 1'b0}) + NUM_W'(count);

	// Restoring step
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign take  = trial >= (REM_W+1)'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STP_W'(NUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload: numerator shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_init;
			div_q <= {count, 1'b0};
			rem_q <= '0;
			neg_q <= sum[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= take ? REM_W'(trial - (REM_W+1)'(div_q)) : REM_W'(trial);
			num_q <= {num_q[NUM_W-2:0], take};
		end
	end

	assign quo  = num_q[COORD_BITS-1:0];
	assign mean = neg_q ? (~quo + 1'b1) : quo;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/pssr_dp.sv
`default_nettype none

module pssr_dp #(
	parameter int MAX_PATH_POINTS = pssr_pkg::MAX_PATH_POINTS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire pssr_pkg::pt_beat_t                    pt_data,
	output logic                                       res_valid,
	input  wire logic                                  res_stall,
	output pssr_pkg::res_beat_t                        res_data,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [pssr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [pssr_pkg::THRESH_BITS-1:0]      cfg_data,
	input  wire pssr_pkg::cmd_t                        cmd,
	output pssr_pkg::sts_t                             sts
);
	import pssr_pkg::*;

	localparam int CNT_W  = $clog2(MAX_PATH_POINTS + 1);
	localparam int SUM_W  = COORD_BITS + CNT_W;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int TSQ_W  = 2 * THRESH_BITS;
	localparam int DIST_W = SQ_W + 1;

	logic signed [COORD_BITS-1:0] px_q, py_q, ax_q, ay_q, lx_q, ly_q;
	logic                         end_q;
	logic signed [SUM_W-1:0]      sum_x_q, sum_y_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [THRESH_BITS-1:0]       thr_q;
	logic [METHOD_BITS-1:0]       method_q;

	logic signed [COORD_BITS:0]     dx, dy;
	logic signed [2*COORD_BITS+1:0] sqx_full, sqy_full;
	logic [TSQ_W-1:0]               tsq;
	logic [SQ_W-1:0]                sq_x_s1, sq_y_s1;
	logic [TSQ_W-1:0]               tsq_s1;
	logic [DIST_W-1:0]              dsq_sum;

	logic                         res_valid_q;
	res_beat_t                    res_q;
	logic                         div_done_x, div_done_y;
	logic signed [COORD_BITS-1:0] mean_x, mean_y;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RST;
			method_q <= MERGE_FIRST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD:    thr_q    <= cfg_data;
				REG_MERGE_METHOD: method_q <= cfg_data[METHOD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Point, anchor and cluster registers
	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			px_q  <= pt_data.point_x;
			py_q  <= pt_data.point_y;
			end_q <= pt_data.end_of_path;
		end
		if (cmd.set_anchor_pt) begin
			ax_q <= px_q;
			ay_q <= py_q;
		end else if (cmd.set_anchor_last) begin
			ax_q <= lx_q;
			ay_q <= ly_q;
		end else if (cmd.set_anchor_mean) begin
			ax_q <= mean_x;
			ay_q <= mean_y;
		end
		if (cmd.open_cluster) begin
			sum_x_q <= SUM_W'(ax_q) + SUM_W'(px_q);
			sum_y_q <= SUM_W'(ay_q) + SUM_W'(py_q);
			cnt_q   <= CNT_W'(2);
			lx_q    <= px_q;
			ly_q    <= py_q;
		end else if (cmd.join_cluster) begin
			// mean stops growing once the cap is reached
			if (cnt_q < CNT_W'(MAX_PATH_POINTS)) begin
				sum_x_q <= sum_x_q + SUM_W'(px_q);
				sum_y_q <= sum_y_q + SUM_W'(py_q);
				cnt_q   <= cnt_q + 1'b1;
			end
			lx_q <= px_q;
			ly_q <= py_q;
		end
	end

	// Squared distance, stage 1: products
	assign dx       = (COORD_BITS+1)'(px_q) - (COORD_BITS+1)'(ax_q);
	assign dy       = (COORD_BITS+1)'(py_q) - (COORD_BITS+1)'(ay_q);
	assign sqx_full = dx * dx;
	assign sqy_full = dy * dy;
	assign tsq      = thr_q * thr_q;

	always_ff @(posedge clk) begin
		sq_x_s1 <= sqx_full[SQ_W-1:0];
		sq_y_s1 <= sqy_full[SQ_W-1:0];
		tsq_s1  <= tsq;
	end

	// Stage 2: sum and compare
	assign dsq_sum = DIST_W'(sq_x_s1) + DIST_W'(sq_y_s1);

	// Mean dividers, x and y in step
	pssr_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.sum    (sum_x_q),
		.count  (cnt_q),
		.done   (div_done_x),
		.mean   (mean_x)
	);

	pssr_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.sum    (sum_y_q),
		.count  (cnt_q),
		.done   (div_done_y),
		.mean   (mean_y)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.out_x    <= ax_q;
			res_q.out_y    <= ay_q;
			res_q.out_last <= cmd.emit_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Status
	always_comb begin
		sts.lt       = dsq_sum < DIST_W'(tsq_s1);
		sts.gt       = dsq_sum > DIST_W'(tsq_s1);
		sts.end_pt   = end_q;
		sts.div_done = div_done_x & div_done_y;
		sts.res_free = !res_valid_q || !res_stall;
		sts.method   = method_q;
	end

endmodule

`default_nettype wire

FILE: sv/pssr_ctrl.sv
`default_nettype none

module pssr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pt_valid,
	output logic                 pt_stall,
	output pssr_pkg::cmd_t       cmd,
	input  wire pssr_pkg::sts_t  sts
);
	import pssr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CMP,
		S_CLOSE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   anchor_valid_q, anchor_valid_d;
	logic   cluster_open_q, cluster_open_d;
	logic   retest_q, retest_d;
	logic   last_q, last_d;

	assign pt_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		anchor_valid_d = anchor_valid_q;
		cluster_open_d = cluster_open_q;
		retest_d       = retest_q;
		last_d         = last_q;
		cmd            = '0;
		cmd.emit_last  = last_q;

		case (state_q)
			S_IDLE: begin
				if (pt_valid) begin
					cmd.load_pt = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!anchor_valid_q) begin
					// first point of a path
					cmd.set_anchor_pt = 1'b1;
					anchor_valid_d    = 1'b1;
					last_d            = 1'b1;
					state_d           = sts.end_pt ? S_EMIT : S_IDLE;
				end else if (cluster_open_q && !sts.gt) begin
					cmd.join_cluster = 1'b1;
					retest_d         = 1'b0;
					state_d          = sts.end_pt ? S_CLOSE : S_IDLE;
				end else if (cluster_open_q) begin
					// point left the cluster: close, then test again
					retest_d = 1'b1;
					state_d  = S_CLOSE;
				end else if (sts.lt) begin
					cmd.open_cluster = 1'b1;
					cluster_open_d   = 1'b1;
					retest_d         = 1'b0;
					state_d          = sts.end_pt ? S_CLOSE : S_IDLE;
				end else begin
					last_d  = 1'b0;
					state_d = S_EMIT;
				end
			end
			S_CLOSE: begin
				cluster_open_d = 1'b0;
				if (sts.method == MERGE_MEAN) begin
					cmd.start_div = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.set_anchor_last = (sts.method == MERGE_LAST);
					last_d              = 1'b1;
					state_d             = retest_q ? S_MUL : S_EMIT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.set_anchor_mean = 1'b1;
					last_d              = 1'b1;
					state_d             = retest_q ? S_MUL : S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.res_free) begin
					cmd.emit = 1'b1;
					if (last_q) begin
						// path done
						anchor_valid_d = 1'b0;
						cluster_open_d = 1'b0;
						state_d        = S_IDLE;
					end else begin
						cmd.set_anchor_pt = 1'b1;
						last_d            = 1'b1;
						state_d           = sts.end_pt ? S_EMIT : S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			anchor_valid_q <= 1'b0;
			cluster_open_q <= 1'b0;
			retest_q       <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			anchor_valid_q <= anchor_valid_d;
			cluster_open_q <= cluster_open_d;
			retest_q       <= retest_d;
			last_q         <= last_d;
		end
	end

endmodule

`default_nettype wire
